[rtl/cspa_pkg.sv]
// Shared types and constants for the canvas slot allocator and packer.
// Holds the slot map sizing, request and status codes, and the command and
// status structs that join the controller to the datapath.
package cspa_pkg;

    localparam int SLOT_COUNT  = 256;
    localparam int IDX_W       = $clog2(SLOT_COUNT);
    localparam int CHUNK_W     = (SLOT_COUNT < 64) ? SLOT_COUNT : 64;
    localparam int CHUNK_COUNT = (SLOT_COUNT + CHUNK_W - 1) / CHUNK_W;
    localparam int CHUNK_SEL_W = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
    localparam int OFF_W       = $clog2(CHUNK_W);
    localparam int PAD_W       = CHUNK_COUNT * CHUNK_W;
    localparam int PAD_IDX_W   = $clog2(PAD_W);

    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 8;
    localparam int ADDR_W   = 32;
    localparam int STRIDE_W = 15;
    localparam int LINES_W  = 13;
    localparam int WRAP_W   = 2;
    localparam int BLOCK_W  = 2;
    localparam int ENDIAN_W = 4;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SETUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd2;

    typedef struct packed {
        logic capture;
        logic step;
        logic commit;
    } cspa_cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic hit;
        logic last;
        logic out_busy;
    } cspa_sts_t;

endpackage

[rtl/cspa_ctrl.sv]
// Controller state machine for the canvas slot allocator and packer.
// Sequences capture, the chunked free-slot search and the result commit.
// Depends on cspa_pkg for the command and status structs.
module cspa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  cspa_pkg::cspa_sts_t sts,
    output cspa_pkg::cspa_cmd_t cmd
);
    import cspa_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        req_stall   = 1'b1;
        cmd.capture = 1'b0;
        cmd.step    = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.step = 1'b1;
                if (!sts.is_alloc || sts.hit || sts.last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/cspa_datapath.sv]
// Datapath for the canvas slot allocator and packer: request registers,
// in-use slot map, chunked lowest-free search, word packing and result register.
// Depends on cspa_pkg for sizing, codes and the command and status structs.
module cspa_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cspa_pkg::cspa_cmd_t              cmd,
    output cspa_pkg::cspa_sts_t              sts,
    input  logic [cspa_pkg::MODE_W-1:0]      mode,
    input  logic [cspa_pkg::SLOT_W-1:0]      slot,
    input  logic [cspa_pkg::ADDR_W-1:0]      base_address,
    input  logic [cspa_pkg::STRIDE_W-1:0]    stride_bytes,
    input  logic [cspa_pkg::LINES_W-1:0]     line_count,
    input  logic [cspa_pkg::WRAP_W-1:0]      wrap_mode,
    input  logic [cspa_pkg::BLOCK_W-1:0]     block_mode,
    input  logic [cspa_pkg::ENDIAN_W-1:0]    endian_mode,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [cspa_pkg::STATUS_W-1:0]    status,
    output logic [cspa_pkg::SLOT_W-1:0]      granted_slot,
    output logic                             lut_write,
    output logic [cspa_pkg::SLOT_W-1:0]      lut_slot,
    output logic [cspa_pkg::WORD_W-1:0]      lut_low_word,
    output logic [cspa_pkg::WORD_W-1:0]      lut_high_word
);
    import cspa_pkg::*;

    logic [MODE_W-1:0]   mode_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [LINES_W-1:0]  lines_reg;
    logic [WRAP_W-1:0]   wrap_reg;
    logic [BLOCK_W-1:0]  block_reg;
    logic [ENDIAN_W-1:0] endian_reg;

    logic [SLOT_COUNT-1:0]  map_reg;
    logic [SLOT_COUNT-1:0]  map_next;
    logic [CHUNK_SEL_W-1:0] chunk_reg;
    logic                   found_reg;
    logic [IDX_W-1:0]       found_idx_reg;

    logic [PAD_W-1:0]     map_pad;
    logic [CHUNK_W-1:0]   chunk_bits;
    logic                 chunk_hit;
    logic [OFF_W-1:0]     chunk_off;
    logic [IDX_W-1:0]     found_idx_next;

    logic                 slot_in_range;
    logic [IDX_W-1:0]     slot_idx;
    logic                 slot_used;
    logic [ADDR_W-1:0]    addr_sum;
    logic [STRIDE_W:0]    stride_sum;
    logic [12:0]          width_units;
    logic [WORD_W-1:0]    low_word;
    logic [WORD_W-1:0]    high_word;

    logic                 rsp_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [SLOT_W-1:0]    granted_reg;
    logic                 lut_write_reg;
    logic [SLOT_W-1:0]    lut_slot_reg;
    logic [WORD_W-1:0]    low_word_reg;
    logic [WORD_W-1:0]    high_word_reg;

    logic [STATUS_W-1:0]  status_next;
    logic [SLOT_W-1:0]    granted_next;
    logic                 lut_write_next;
    logic [SLOT_W-1:0]    lut_slot_next;
    logic [WORD_W-1:0]    low_word_next;
    logic [WORD_W-1:0]    high_word_next;

    // Slots past the end of the map read as used so the search never picks them.
    always_comb
    begin
        map_pad                 = '1;
        map_pad[SLOT_COUNT-1:0] = map_reg;
        chunk_bits              = map_pad[chunk_reg * CHUNK_W +: CHUNK_W];
    end

    always_comb
    begin
        chunk_hit = 1'b0;
        chunk_off = '0;
        for (int j = CHUNK_W - 1; j >= 0; j--)
        begin
            if (!chunk_bits[j])
            begin
                chunk_hit = 1'b1;
                chunk_off = OFF_W'(j);
            end
        end
    end

    assign found_idx_next = IDX_W'(PAD_IDX_W'(chunk_reg) * PAD_IDX_W'(CHUNK_W)
                                   + PAD_IDX_W'(chunk_off));

    assign sts.is_alloc = (mode_reg == MODE_ALLOC);
    assign sts.hit      = chunk_hit;
    assign sts.last     = (chunk_reg == CHUNK_SEL_W'(CHUNK_COUNT - 1));
    assign sts.out_busy = rsp_valid_reg && rsp_stall;

    assign slot_in_range = ({1'b0, slot_reg} < (SLOT_W + 1)'(SLOT_COUNT));
    assign slot_idx      = slot_reg[IDX_W-1:0];
    assign slot_used     = slot_in_range && map_reg[slot_idx];

    assign addr_sum    = addr_reg + ADDR_W'(7);
    assign stride_sum  = {1'b0, stride_reg} + (STRIDE_W + 1)'(7);
    assign width_units = stride_sum[STRIDE_W:3];
    assign low_word    = {width_units[2:0], addr_sum[ADDR_W-1:3]};
    assign high_word   = {22'b0, width_units[12:3]}
                       | {10'b0, lines_reg, 9'b0}
                       | {8'b0, wrap_reg, 22'b0}
                       | {6'b0, block_reg, 24'b0}
                       | {2'b0, endian_reg, 26'b0};

    always_comb
    begin
        map_next       = map_reg;
        status_next    = ST_OK;
        granted_next   = '0;
        lut_write_next = 1'b0;
        lut_slot_next  = '0;
        low_word_next  = '0;
        high_word_next = '0;
        unique case (mode_reg)
            MODE_ALLOC:
            begin
                if (found_reg)
                begin
                    map_next[found_idx_reg] = 1'b1;
                    granted_next            = SLOT_W'(found_idx_reg);
                end
                else
                begin
                    status_next = ST_NO_FREE;
                end
            end
            MODE_FREE:
            begin
                if (slot_used)
                begin
                    map_next[slot_idx] = 1'b0;
                end
                else
                begin
                    status_next = ST_NOT_USED;
                end
            end
            MODE_SETUP:
            begin
                if (slot_used)
                begin
                    lut_write_next = 1'b1;
                    lut_slot_next  = slot_reg;
                    low_word_next  = low_word;
                    high_word_next = high_word;
                end
                else
                begin
                    status_next = ST_NOT_USED;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= mode;
            slot_reg   <= slot;
            addr_reg   <= base_address;
            stride_reg <= stride_bytes;
            lines_reg  <= line_count;
            wrap_reg   <= wrap_mode;
            block_reg  <= block_mode;
            endian_reg <= endian_mode;
        end
        if (cmd.step && chunk_hit)
        begin
            found_idx_reg <= found_idx_next;
        end
        if (cmd.commit)
        begin
            status_reg    <= status_next;
            granted_reg   <= granted_next;
            lut_write_reg <= lut_write_next;
            lut_slot_reg  <= lut_slot_next;
            low_word_reg  <= low_word_next;
            high_word_reg <= high_word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg       <= '0;
            chunk_reg     <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                chunk_reg <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                if (chunk_hit)
                begin
                    found_reg <= 1'b1;
                end
                else if (!sts.last)
                begin
                    chunk_reg <= chunk_reg + CHUNK_SEL_W'(1);
                end
            end
            if (cmd.commit)
            begin
                map_reg       <= map_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign granted_slot  = granted_reg;
    assign lut_write     = lut_write_reg;
    assign lut_slot      = lut_slot_reg;
    assign lut_low_word  = low_word_reg;
    assign lut_high_word = high_word_reg;

endmodule

[rtl/canvas_slot_allocator_and_packer.sv]
// Top level of the canvas slot allocator and packer.
// Joins the controller (cspa_ctrl) and the datapath (cspa_datapath); uses cspa_pkg.
//
// The block handles one request at a time. A request is captured into the
// request registers, then the in-use map is scanned 64 slots a cycle for the
// lowest free slot: an allocate scans up to four chunks until one holds a free
// slot, while free and setup leave after the first chunk. A final state then
// checks the slot, packs the lookup words and, once the output is not stalled,
// loads the result register. The next request is accepted while the previous
// result still waits in that register. All slots are free after reset.
module canvas_slot_allocator_and_packer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [cspa_pkg::MODE_W-1:0]      mode,
    input  logic [cspa_pkg::SLOT_W-1:0]      slot,
    input  logic [cspa_pkg::ADDR_W-1:0]      base_address,
    input  logic [cspa_pkg::STRIDE_W-1:0]    stride_bytes,
    input  logic [cspa_pkg::LINES_W-1:0]     line_count,
    input  logic [cspa_pkg::WRAP_W-1:0]      wrap_mode,
    input  logic [cspa_pkg::BLOCK_W-1:0]     block_mode,
    input  logic [cspa_pkg::ENDIAN_W-1:0]    endian_mode,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [cspa_pkg::STATUS_W-1:0]    status,
    output logic [cspa_pkg::SLOT_W-1:0]      granted_slot,
    output logic                             lut_write,
    output logic [cspa_pkg::SLOT_W-1:0]      lut_slot,
    output logic [cspa_pkg::WORD_W-1:0]      lut_low_word,
    output logic [cspa_pkg::WORD_W-1:0]      lut_high_word
);
    import cspa_pkg::*;

    cspa_cmd_t cmd;
    cspa_sts_t sts;

    cspa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    cspa_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .mode          (mode),
        .slot          (slot),
        .base_address  (base_address),
        .stride_bytes  (stride_bytes),
        .line_count    (line_count),
        .wrap_mode     (wrap_mode),
        .block_mode    (block_mode),
        .endian_mode   (endian_mode),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .granted_slot  (granted_slot),
        .lut_write     (lut_write),
        .lut_slot      (lut_slot),
        .lut_low_word  (lut_low_word),
        .lut_high_word (lut_high_word)
    );

    // The block is busy in the cycle after taking an item.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while a previous item was in flight");

    // A result is committed only while the controller holds off new items.
    a_commit_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> req_stall && !cmd.capture)
        else $error("result committed while requests were open");

    // Lookup words are flagged only for a successful setup.
    a_lut_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && lut_write) |-> (status == ST_OK) && (granted_slot == '0))
        else $error("lookup write flagged on a failed or non-setup item");

    // A failed allocate never reports a granted slot.
    a_no_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_NO_FREE) |-> (granted_slot == '0) && !lut_write)
        else $error("failed allocate carries a slot or lookup write");

endmodule
